// File: src/rsld_pkg.sv
// Shared types and constants for the run-length sprite line decoder.
package rsld_pkg;

	localparam int unsigned QDepth = 4;
	localparam int unsigned QAw = $clog2(QDepth);

	localparam logic [2:0] PH_OFFSET = 3'd0;
	localparam logic [2:0] PH_SKIP = 3'd1;
	localparam logic [2:0] PH_DIMS = 3'd2;
	localparam logic [2:0] PH_LINE = 3'd3;
	localparam logic [2:0] PH_CTRL = 3'd4;
	localparam logic [2:0] PH_FILL = 3'd5;
	localparam logic [2:0] PH_LIT = 3'd6;
	localparam logic [2:0] PH_DONE = 3'd7;

	localparam logic [1:0] ST_PIXEL = 2'd0;
	localparam logic [1:0] ST_COMPLETE = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;
	localparam logic [1:0] ST_TRUNC = 2'd3;

	localparam logic [7:0] LEN_MASK = 8'h3F;
	localparam logic [7:0] RUN_MASK = 8'hC0;
	localparam logic [7:0] LIT_BIT = 8'h40;

	localparam logic [6:0] MAX_RESULTS = 7'd64;

	typedef struct packed {
		logic [7:0] x_start;
		logic [6:0] vis;
		logic [7:0] y;
		logic [7:0] color;
		logic       st_valid;
		logic [1:0] st;
	} cmd_t;

endpackage

// File: src/rsld_front.sv
// Byte parser that turns each accepted byte into at most one expansion command.
module rsld_front import rsld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] byte_value,
	input  logic       first_byte,
	input  logic       last_byte,
	input  logic       push,
	output logic       full,
	output logic       cmd_valid,
	output cmd_t       cmd,
	input  logic       cmd_ready
);

	logic [2:0]  phase_q, phase_n, ph_c;
	logic [2:0]  hc_q, hc_n, hc_c, hc_inc;
	logic [31:0] acc_q, acc_n, acc_c;
	logic [31:0] skip_q, skip_n;
	logic [7:0]  width_q, width_n;
	logic [7:0]  height_q, height_n;
	logic [7:0]  line_q, line_n;
	logic [7:0]  runs_q, runs_n;
	logic [6:0]  lit_q, lit_n;
	logic [15:0] col_q, col_n;
	logic        run_en;
	logic [6:0]  run_len;
	logic        end_run, end_line;
	logic        st_valid;
	logic [1:0]  st;
	logic [16:0] col_sum;
	logic [7:0]  room;
	logic [6:0]  vis;
	logic        accept;

	assign full = !cmd_ready;
	assign accept = push && cmd_ready;

	always_comb begin
		ph_c = first_byte ? PH_OFFSET : phase_q;
		hc_c = first_byte ? 3'd0 : hc_q;
		acc_c = first_byte ? 32'd0 : acc_q;
		hc_inc = hc_c + 3'd1;
		phase_n = ph_c;
		hc_n = hc_c;
		acc_n = acc_c;
		skip_n = skip_q;
		width_n = width_q;
		height_n = height_q;
		line_n = line_q;
		runs_n = runs_q;
		lit_n = lit_q;
		col_n = col_q;
		run_en = 1'b0;
		run_len = 7'd1;
		end_run = 1'b0;
		end_line = 1'b0;
		st_valid = 1'b0;
		st = ST_PIXEL;
		col_sum = 17'd0;
		unique case (ph_c)
			PH_OFFSET: begin
				acc_n = acc_c | ({24'd0, byte_value} << {hc_c[1:0], 3'b000});
				if (hc_inc[2]) begin
					hc_n = 3'd0;
					skip_n = (acc_n >= 32'd4) ? acc_n - 32'd4 : 32'd0;
					phase_n = (skip_n != 32'd0) ? PH_SKIP : PH_DIMS;
				end else begin
					hc_n = hc_inc;
				end
			end
			PH_SKIP: begin
				skip_n = skip_q - 32'd1;
				if (skip_n == 32'd0) begin
					phase_n = PH_DIMS;
				end
			end
			PH_DIMS: begin
				if (hc_c == 3'd0) begin
					width_n = byte_value;
				end else if (hc_c == 3'd1) begin
					height_n = byte_value;
				end
				if (hc_inc[2]) begin
					hc_n = 3'd0;
					line_n = 8'd0;
					col_n = 16'd0;
					if (width_n == 8'd0 || height_n == 8'd0) begin
						phase_n = PH_DONE;
						st_valid = 1'b1;
						st = ST_EMPTY;
					end else begin
						phase_n = PH_LINE;
					end
				end else begin
					hc_n = hc_inc;
				end
			end
			PH_LINE: begin
				col_n = 16'd0;
				runs_n = byte_value;
				if (byte_value == 8'd0) begin
					end_line = 1'b1;
				end else begin
					phase_n = PH_CTRL;
				end
			end
			PH_CTRL: begin
				if ((byte_value & RUN_MASK) != 8'd0) begin
					lit_n = {1'b0, byte_value[5:0]} + 7'd1;
					phase_n = ((byte_value & LIT_BIT) != 8'd0) ? PH_LIT : PH_FILL;
				end else begin
					col_sum = {1'b0, col_q} + 17'(byte_value & LEN_MASK) + 17'd1;
					col_n = col_sum[16] ? 16'hFFFF : col_sum[15:0];
					end_run = 1'b1;
				end
			end
			PH_FILL: begin
				run_en = 1'b1;
				run_len = lit_q;
				col_sum = {1'b0, col_q} + 17'(lit_q);
				col_n = col_sum[16] ? 16'hFFFF : col_sum[15:0];
				lit_n = 7'd0;
				end_run = 1'b1;
			end
			PH_LIT: begin
				run_en = 1'b1;
				col_n = (col_q == 16'hFFFF) ? col_q : col_q + 16'd1;
				lit_n = lit_q - 7'd1;
				if (lit_n == 7'd0) begin
					end_run = 1'b1;
				end
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase
		if (end_run) begin
			runs_n = runs_q - 8'd1;
			if (runs_n == 8'd0) begin
				end_line = 1'b1;
			end else begin
				phase_n = PH_CTRL;
			end
		end
		if (end_line) begin
			col_n = 16'd0;
			line_n = line_q + 8'd1;
			if (line_n >= height_q) begin
				phase_n = PH_DONE;
				st_valid = 1'b1;
				st = ST_COMPLETE;
			end else begin
				phase_n = PH_LINE;
			end
		end
		if (last_byte && phase_n != PH_DONE) begin
			phase_n = PH_DONE;
			st_valid = 1'b1;
			st = ST_TRUNC;
		end
	end

	always_comb begin
		room = width_q - col_q[7:0];
		vis = 7'd0;
		if (run_en && col_q < {8'd0, width_q}) begin
			vis = ({1'b0, run_len} <= room) ? run_len : room[6:0];
		end
		if (st_valid && vis == MAX_RESULTS) begin
			vis = MAX_RESULTS - 7'd1;
		end
	end

	assign cmd_valid = accept && (vis != 7'd0 || st_valid);
	assign cmd.x_start = col_q[7:0];
	assign cmd.vis = vis;
	assign cmd.y = line_q;
	assign cmd.color = byte_value;
	assign cmd.st_valid = st_valid;
	assign cmd.st = st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_OFFSET;
			hc_q <= 3'd0;
			acc_q <= 32'd0;
			skip_q <= 32'd0;
			width_q <= 8'd0;
			height_q <= 8'd0;
			line_q <= 8'd0;
			runs_q <= 8'd0;
			lit_q <= 7'd0;
			col_q <= 16'd0;
		end else if (accept) begin
			phase_q <= phase_n;
			hc_q <= hc_n;
			acc_q <= acc_n;
			skip_q <= skip_n;
			width_q <= width_n;
			height_q <= height_n;
			line_q <= line_n;
			runs_q <= runs_n;
			lit_q <= lit_n;
			col_q <= col_n;
		end
	end

endmodule

// File: src/rsld_fifo.sv
// Short command queue between the parser and the pixel expander.
module rsld_fifo import rsld_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	input  cmd_t wr_data,
	output logic wr_ready,
	output logic rd_valid,
	output cmd_t rd_data,
	input  logic rd_ready
);

	cmd_t           mem_q [QDepth];
	logic [QAw-1:0] wr_ptr_q, rd_ptr_q;
	logic [QAw:0]   count_q;
	logic           do_wr, do_rd;

	assign wr_ready = count_q != (QAw+1)'(QDepth);
	assign rd_valid = count_q != '0;
	assign rd_data = mem_q[rd_ptr_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + QAw'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + QAw'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + (QAw+1)'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - (QAw+1)'(1);
			end
		end
	end

endmodule

// File: src/rsld_back.sv
// Expander that turns queued commands into pixel and status words.
module rsld_back import rsld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cmd_valid,
	input  cmd_t       cmd,
	output logic       cmd_pop,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] status,
	output logic [7:0] pixel_x,
	output logic [7:0] pixel_y,
	output logic [7:0] color_index,
	output logic       last_of_run
);

	logic       out_valid_q;
	logic [6:0] k_q;
	logic       load;
	logic       in_pixels;
	logic       last_pixel;

	assign empty = !out_valid_q;
	assign load = !out_valid_q || pop;
	assign in_pixels = k_q < cmd.vis;
	assign last_pixel = (k_q + 7'd1) == cmd.vis;
	assign cmd_pop = load && cmd_valid && (!in_pixels || (last_pixel && !cmd.st_valid));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			k_q <= 7'd0;
		end else if (load) begin
			out_valid_q <= cmd_valid;
			if (cmd_valid) begin
				k_q <= cmd_pop ? 7'd0 : k_q + 7'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && cmd_valid) begin
			if (in_pixels) begin
				status <= ST_PIXEL;
				pixel_x <= cmd.x_start + {1'b0, k_q};
				pixel_y <= cmd.y;
				color_index <= cmd.color;
				last_of_run <= last_pixel && !cmd.st_valid;
			end else begin
				status <= cmd.st;
				pixel_x <= 8'd0;
				pixel_y <= 8'd0;
				color_index <= 8'd0;
				last_of_run <= 1'b1;
			end
		end
	end

endmodule

// File: src/rle_sprite_line_decoder_unit.sv
// A byte's first word passes through the command queue and then the output register.
// One byte per cycle goes in while the queue has room, one word out while pop is high.
// A fill byte with n visible pixels holds the expander for n result words; bytes keep entering
// until the four-entry command queue fills, then full stays high.
// Reset (arst_n low) clears the parser state, the queue and the output valid at once.
module rle_sprite_line_decoder_unit import rsld_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] byte_value,
	input  logic       first_byte,
	input  logic       last_byte,
	input  logic       push,
	output logic       full,
	output logic       empty,
	input  logic       pop,
	output logic [1:0] status,
	output logic [7:0] pixel_x,
	output logic [7:0] pixel_y,
	output logic [7:0] color_index,
	output logic       last_of_run
);

	logic f_valid, f_ready, b_valid, b_pop;
	cmd_t f_cmd, b_cmd;

	rsld_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_value (byte_value),
		.first_byte (first_byte),
		.last_byte  (last_byte),
		.push       (push),
		.full       (full),
		.cmd_valid  (f_valid),
		.cmd        (f_cmd),
		.cmd_ready  (f_ready)
	);

	rsld_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_data  (f_cmd),
		.wr_ready (f_ready),
		.rd_valid (b_valid),
		.rd_data  (b_cmd),
		.rd_ready (b_pop)
	);

	rsld_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (b_valid),
		.cmd         (b_cmd),
		.cmd_pop     (b_pop),
		.empty       (empty),
		.pop         (pop),
		.status      (status),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.color_index (color_index),
		.last_of_run (last_of_run)
	);

endmodule

// File: bench/rle_sprite_line_decoder_checker.sv
// Checker for the run-length sprite line decoder: predicts every result word and compares it.
module rle_sprite_line_decoder_checker import rsld_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [7:0]        byte_value,
	input  logic              first_byte,
	input  logic              last_byte,
	input  logic              push,
	input  logic              full,
	input  logic              empty,
	input  logic              pop,
	input  logic [1:0]        status,
	input  logic [7:0]        pixel_x,
	input  logic [7:0]        pixel_y,
	input  logic [7:0]        color_index,
	input  logic              last_of_run,
	output int unsigned       outstanding,
	output int unsigned       fail_count
);

	typedef struct packed {
		logic [1:0] st;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] color;
		logic       tail;
	} word_t;

	logic [2:0]  phase;
	logic [2:0]  hdr_count;
	logic [31:0] offset_acc;
	logic [31:0] skip_left;
	logic [7:0]  width;
	logic [7:0]  height;
	logic [7:0]  row;
	logic [7:0]  runs_left;
	logic [6:0]  lit_left;
	logic [15:0] column;

	word_t       byte_words[$];
	word_t       pending_words[$];
	int unsigned words_seen;

	function automatic void restart_parse();
		phase = PH_OFFSET;
		hdr_count = '0;
		offset_acc = '0;
		skip_left = '0;
		width = '0;
		height = '0;
		row = '0;
		runs_left = '0;
		lit_left = '0;
		column = '0;
	endfunction

	function automatic void emit_pixel(logic [7:0] color);
		word_t w;
		if (column < {8'd0, width} && byte_words.size() < MAX_RESULTS) begin
			w = '{st: ST_PIXEL, x: column[7:0], y: row, color: color, tail: 1'b0};
			byte_words.push_back(w);
		end
		if (column != 16'hFFFF)
			column = column + 16'd1;
	endfunction

	// A status always gets through: it replaces the last pixel when the byte is at its limit.
	function automatic void emit_status(logic [1:0] code);
		word_t w;
		while (byte_words.size() >= MAX_RESULTS)
			void'(byte_words.pop_back());
		w = '{st: code, x: 8'd0, y: 8'd0, color: 8'd0, tail: 1'b0};
		byte_words.push_back(w);
	endfunction

	function automatic void close_line();
		column = '0;
		row = row + 8'd1;
		if (row >= height) begin
			phase = PH_DONE;
			emit_status(ST_COMPLETE);
		end else begin
			phase = PH_LINE;
		end
	endfunction

	function automatic void close_run();
		runs_left = runs_left - 8'd1;
		if (runs_left == 0)
			close_line();
		else
			phase = PH_CTRL;
	endfunction

	function automatic void decode_byte(logic [7:0] b, logic first, logic last);
		logic [16:0] sum;
		byte_words.delete();
		if (first)
			restart_parse();
		case (phase)
			PH_OFFSET: begin
				offset_acc = offset_acc | ({24'd0, b} << (8 * hdr_count[1:0]));
				hdr_count = hdr_count + 3'd1;
				if (hdr_count >= 3'd4) begin
					hdr_count = '0;
					skip_left = (offset_acc >= 32'd4) ? offset_acc - 32'd4 : 32'd0;
					phase = (skip_left != 0) ? PH_SKIP : PH_DIMS;
				end
			end
			PH_SKIP: begin
				skip_left = skip_left - 32'd1;
				if (skip_left == 0)
					phase = PH_DIMS;
			end
			PH_DIMS: begin
				if (hdr_count == 3'd0)
					width = b;
				else if (hdr_count == 3'd1)
					height = b;
				hdr_count = hdr_count + 3'd1;
				if (hdr_count >= 3'd4) begin
					hdr_count = '0;
					row = '0;
					column = '0;
					if (width == 0 || height == 0) begin
						phase = PH_DONE;
						emit_status(ST_EMPTY);
					end else begin
						phase = PH_LINE;
					end
				end
			end
			PH_LINE: begin
				column = '0;
				runs_left = b;
				if (runs_left == 0)
					close_line();
				else
					phase = PH_CTRL;
			end
			PH_CTRL: begin
				if ((b & RUN_MASK) != 0) begin
					lit_left = 7'((b & LEN_MASK) + 8'd1);
					phase = ((b & LIT_BIT) != 0) ? PH_LIT : PH_FILL;
				end else begin
					sum = {1'b0, column} + 17'(b & LEN_MASK) + 17'd1;
					column = sum[16] ? 16'hFFFF : sum[15:0];
					close_run();
				end
			end
			PH_FILL: begin
				for (int i = 0; i < lit_left; i++)
					emit_pixel(b);
				lit_left = '0;
				close_run();
			end
			PH_LIT: begin
				emit_pixel(b);
				lit_left = lit_left - 7'd1;
				if (lit_left == 0)
					close_run();
			end
			default: begin
			end
		endcase
		if (last && phase != PH_DONE) begin
			phase = PH_DONE;
			emit_status(ST_TRUNC);
		end
		if (byte_words.size() > 0)
			byte_words[byte_words.size() - 1].tail = 1'b1;
		foreach (byte_words[i])
			pending_words.push_back(byte_words[i]);
	endfunction

	task automatic report_mismatch(input string msg);
		if (fail_count < 50)
			$display("%0t checker: %s", $time, msg);
		fail_count++;
	endtask

	always @(posedge clk) begin
		word_t want;
		if (!arst_n) begin
			fail_count = 0;
			words_seen = 0;
			restart_parse();
			pending_words.delete();
			outstanding <= 0;
		end else begin
			if (push && !full)
				decode_byte(byte_value, first_byte, last_byte);
			if (pop && !empty) begin
				if (pending_words.size() == 0) begin
					report_mismatch($sformatf("word %0d arrived with nothing expected", words_seen));
				end else begin
					want = pending_words.pop_front();
					if (status !== want.st)
						report_mismatch($sformatf("word %0d status %0d, expected %0d",
							words_seen, status, want.st));
					if (pixel_x !== want.x)
						report_mismatch($sformatf("word %0d pixel_x %0d, expected %0d",
							words_seen, pixel_x, want.x));
					if (pixel_y !== want.y)
						report_mismatch($sformatf("word %0d pixel_y %0d, expected %0d",
							words_seen, pixel_y, want.y));
					if (color_index !== want.color)
						report_mismatch($sformatf("word %0d color_index %0h, expected %0h",
							words_seen, color_index, want.color));
					if (last_of_run !== want.tail)
						report_mismatch($sformatf("word %0d last_of_run %0b, expected %0b",
							words_seen, last_of_run, want.tail));
				end
				words_seen++;
			end
			outstanding <= pending_words.size();
		end
	end

endmodule

// File: bench/rle_sprite_line_decoder_unit_tb.sv
// Testbench top for the run-length sprite line decoder: stimulus, stalls and the verdict.
module rle_sprite_line_decoder_unit_tb import rsld_pkg::*; ();

	localparam int unsigned ItemTarget = 220;
	localparam int unsigned IdleLimit = 2000;
	localparam int unsigned DrainCycles = 8;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic [7:0]  byte_value = 8'd0;
	logic        first_byte = 1'b0;
	logic        last_byte = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  status;
	logic [7:0]  pixel_x;
	logic [7:0]  pixel_y;
	logic [7:0]  color_index;
	logic        last_of_run;
	int unsigned outstanding;
	int unsigned fail_count;

	logic [7:0]  sprite_bytes[$];
	int          burst_left = 0;
	int unsigned bytes_sent = 0;
	int unsigned buffers_sent = 0;
	int unsigned words_taken = 0;
	int unsigned quiet_cycles = 0;
	logic [5:0]  pop_tick = '0;

	rle_sprite_line_decoder_unit u_dut (.*);

	rle_sprite_line_decoder_checker u_checker (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		pop_tick <= pop_tick + 6'd1;
		case (pop_tick[5:4])
			2'd0: pop <= 1'b1;
			2'd1: pop <= 1'($urandom_range(0, 1));
			2'd2: pop <= ($urandom_range(0, 3) != 0);
			default: pop <= pop_tick[3];
		endcase
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (pop && !empty)
				words_taken <= words_taken + 1;
			if (quiet_cycles >= IdleLimit) begin
				$display("Timed out after %0d cycles with no word accepted.", quiet_cycles);
				$display("rle_sprite_line_decoder_unit_tb: FAIL");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic f, input logic l);
		if (burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
		end
		byte_value <= b;
		first_byte <= f;
		last_byte <= l;
		push <= 1'b1;
		do @(posedge clk); while (full);
		burst_left--;
	endtask

	// A negative cut sends the whole buffer; otherwise the byte at the cut carries last_byte.
	task automatic send_buffer(input bit lead_first, input int cut);
		int n;
		n = (cut >= 0) ? cut + 1 : sprite_bytes.size();
		for (int i = 0; i < n; i++)
			send_byte(sprite_bytes[i], lead_first && i == 0, i == cut);
		bytes_sent += n;
		buffers_sent++;
	endtask

	task automatic wait_for_drain();
		push <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	initial begin
		int ofs;
		int w;
		int h;
		int nruns;
		int len;
		int cut;
		int pick;
		logic [7:0] ctrl;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Offset of zero with no leading first_byte, a clipped literal, and a full-width fill
		// on the final run so that the completion word displaces the last pixel.
		sprite_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'd64, 8'd2, 8'h00, 8'h00,
			8'd2, 8'h3F, 8'h40, 8'h00, 8'd1, 8'hBF, 8'hFF};
		send_buffer(1'b0, -1);
		sprite_bytes = '{8'h04, 8'h00, 8'h00, 8'h00, 8'd0, 8'd3, 8'hFF, 8'hFF};
		send_buffer(1'b1, -1);
		sprite_bytes = '{8'hFF, 8'hFF};
		send_buffer(1'b1, 1);
		wait_for_drain();

		while (bytes_sent < ItemTarget) begin
			sprite_bytes.delete();
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(1, 12)) sprite_bytes.push_back(8'($urandom));
			end else begin
				ofs = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 9);
				sprite_bytes = '{8'(ofs), 8'h00, 8'h00, 8'h00};
				for (int i = 4; i < ofs; i++)
					sprite_bytes.push_back(8'($urandom));
				pick = $urandom_range(0, 19);
				w = (pick == 0) ? 0 : (pick < 3) ? $urandom_range(64, 255) : $urandom_range(1, 12);
				h = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 4);
				sprite_bytes.push_back(8'(w));
				sprite_bytes.push_back(8'(h));
				sprite_bytes.push_back(8'($urandom));
				sprite_bytes.push_back(8'($urandom));
				if (w != 0 && h != 0) begin
					for (int y = 0; y < h; y++) begin
						nruns = $urandom_range(0, 4);
						sprite_bytes.push_back(8'(nruns));
						for (int r = 0; r < nruns; r++) begin
							len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 5);
							case ($urandom_range(0, 2))
								0: sprite_bytes.push_back(8'(len) & LEN_MASK);
								1: begin
									sprite_bytes.push_back((RUN_MASK & ~LIT_BIT) | 8'(len));
									sprite_bytes.push_back(8'($urandom));
								end
								default: begin
									ctrl = ($urandom_range(0, 1) != 0) ? RUN_MASK : LIT_BIT;
									sprite_bytes.push_back(ctrl | 8'(len));
									repeat (len + 1) sprite_bytes.push_back(8'($urandom));
								end
							endcase
						end
					end
				end
			end
			pick = $urandom_range(0, 7);
			if (pick == 0)
				cut = $urandom_range(0, sprite_bytes.size() - 1);
			else if (pick < 4)
				cut = sprite_bytes.size() - 1;
			else
				cut = -1;
			send_buffer($urandom_range(0, 15) != 0, cut);
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0, 1'($urandom));
			if ($urandom_range(0, 7) == 0)
				wait_for_drain();
		end

		wait_for_drain();
		repeat (DrainCycles) @(posedge clk);
		$display("Sent %0d buffers (%0d bytes) and checked %0d result words,", buffers_sent,
			bytes_sent, words_taken);
		$display("covering skips, fills, literals, clipping, empty, complete and truncated sprites.");
		if (fail_count == 0)
			$display("rle_sprite_line_decoder_unit_tb: PASS");
		else
			$display("rle_sprite_line_decoder_unit_tb: FAIL");
		$finish;
	end

endmodule

// File: sim.f
src/rsld_pkg.sv
src/rsld_front.sv
src/rsld_fifo.sv
src/rsld_back.sv
src/rle_sprite_line_decoder_unit.sv
bench/rle_sprite_line_decoder_checker.sv
bench/rle_sprite_line_decoder_unit_tb.sv
